### rtl/core/dawsel_pkg.sv
// Package for the data-aware worker selector: payload structs, command and register codes,
// controller/datapath command and status structs. No dependencies.
package dawsel_pkg;

    localparam logic CMD_ESTIMATE = 1'b0;
    localparam logic CMD_TAKEN    = 1'b1;

    localparam logic [1:0] REG_ALPHA  = 2'd0;
    localparam logic [1:0] REG_BETA   = 2'd1;
    localparam logic [1:0] REG_ACTIVE = 2'd2;

    localparam logic [31:0] TMAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        command;
        logic [2:0]  worker;
        logic        eligible;
        logic        known;
        logic [23:0] length;
        logic [23:0] penalty;
        logic        priority_req;
        logic        last;
        logic [31:0] now;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  chosen_worker;
        logic [23:0] charged_length;
        logic [23:0] charged_penalty;
        logic        to_front;
        logic        was_forced;
        logic        none_eligible;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_TAKEN,
        OP_SCAN_END,
        OP_SCAN_FIT,
        OP_FIT_MUL,
        OP_CHARGE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   clear_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic is_taken;
        logic is_last;
        logic idx_done;
        logic forced;
    } dp_status_t;

endpackage

### rtl/core/data_aware_worker_selector.sv
// Data-aware worker selector, top level: APB registers, controller, datapath.
// Sequence: a job-taken or non-last estimate is loaded and dispatched; a last
// estimate then runs the end scan over the N active workers and, unless a
// worker is forced, a multiply and compare step per worker, then the charge.
// One item at a time: the next item is accepted once the result is taken.
// Reset (aresetn, synchronous): gains 1.0, eight active workers, times cleared.
module data_aware_worker_selector #(
    parameter int WORKERS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dawsel_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dawsel_pkg::out_item_t m_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic [15:0] alpha_reg, beta_reg;
    logic [3:0]  active_reg;
    dawsel_pkg::dp_cmd_t    cmd;
    dawsel_pkg::dp_status_t status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= 16'd256;
            beta_reg   <= 16'd256;
            active_reg <= 4'd8;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                dawsel_pkg::REG_ALPHA:  alpha_reg  <= pwdata[15:0];
                dawsel_pkg::REG_BETA:   beta_reg   <= pwdata[15:0];
                dawsel_pkg::REG_ACTIVE: active_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dawsel_pkg::REG_ALPHA:  prdata = {16'd0, alpha_reg};
            dawsel_pkg::REG_BETA:   prdata = {16'd0, beta_reg};
            dawsel_pkg::REG_ACTIVE: prdata = {28'd0, active_reg};
            default:                prdata = '0;
        endcase
    end

    dawsel_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .status, .cmd
    );

    dawsel_datapath #(.WORKERS(WORKERS)) u_dp (
        .aclk, .aresetn, .item(s_item), .cmd,
        .alpha_gain(alpha_reg), .beta_gain(beta_reg), .active_workers(active_reg),
        .status, .result(m_item)
    );
endmodule

### rtl/core/dawsel_datapath.sv
// Datapath of the worker selector: per-worker state, estimate store,
// end-time and fitness scans over a shared index. Depends on dawsel_pkg.
module dawsel_datapath #(
    parameter int WORKERS = 8,
    parameter int IW = (WORKERS > 1) ? $clog2(WORKERS) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dawsel_pkg::in_item_t   item,
    input  dawsel_pkg::dp_cmd_t    cmd,
    input  logic [15:0]            alpha_gain,
    input  logic [15:0]            beta_gain,
    input  logic [3:0]             active_workers,
    output dawsel_pkg::dp_status_t status,
    output dawsel_pkg::out_item_t  result
);
    localparam int CW = $clog2(WORKERS + 1);

    logic [31:0] start_reg [WORKERS];
    logic [31:0] qlen_reg  [WORKERS];
    logic [31:0] end_reg   [WORKERS];
    logic [23:0] elen_reg  [WORKERS];
    logic [23:0] epen_reg  [WORKERS];
    logic        eelig_reg [WORKERS];
    logic        eknown_reg[WORKERS];
    logic [31:0] ends_reg  [WORKERS];

    dawsel_pkg::in_item_t item_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] n_reg;
    logic [31:0]   best_end_reg;
    logic          have_end_reg;
    logic          have_best_reg;
    logic          forced_reg;
    logic [IW-1:0] best_reg;
    logic [63:0]   best_fit_reg;
    logic [47:0]   prod_a_reg;
    logic [39:0]   prod_b_reg;

    logic [IW-1:0] ix;
    logic          in_range;
    logic [IW-1:0] wi;
    logic [63:0]   fit;
    logic [31:0]   diff;

    function automatic logic [31:0] sat(input logic [32:0] s);
        return s[32] ? dawsel_pkg::TMAX : s[31:0];
    endfunction

    assign ix       = idx_reg[IW-1:0];
    assign wi       = IW'(item_reg.worker);
    assign in_range = 32'(item_reg.worker) < 32'(WORKERS);

    always_comb begin
        diff = ends_reg[ix] - best_end_reg;
        fit  = {16'd0, prod_a_reg} + {24'd0, prod_b_reg};
    end

    assign status.is_taken = item_reg.command == dawsel_pkg::CMD_TAKEN;
    assign status.is_last  = item_reg.last;
    assign status.idx_done = idx_reg >= n_reg;
    assign status.forced   = forced_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORKERS; i++) begin
                start_reg[i] <= '0;
                qlen_reg[i]  <= '0;
                end_reg[i]   <= '0;
            end
            idx_reg <= '0;
        end else begin
            if (cmd.clear_idx) begin
                idx_reg       <= '0;
                have_best_reg <= 1'b0;
            end
            case (cmd.op)
                dawsel_pkg::OP_LOAD: begin
                    item_reg      <= item;
                    n_reg         <= (32'(active_workers) > 32'(WORKERS)) ?
                                     CW'(WORKERS) : CW'(active_workers);
                    have_end_reg  <= 1'b0;
                    have_best_reg <= 1'b0;
                    forced_reg    <= 1'b0;
                    best_reg      <= '0;
                    best_end_reg  <= dawsel_pkg::TMAX;
                    idx_reg       <= '0;
                    if (item.command == dawsel_pkg::CMD_ESTIMATE &&
                        32'(item.worker) < 32'(WORKERS)) begin
                        elen_reg[IW'(item.worker)]   <= item.length;
                        epen_reg[IW'(item.worker)]   <= item.penalty;
                        eelig_reg[IW'(item.worker)]  <= item.eligible;
                        eknown_reg[IW'(item.worker)] <= item.known;
                    end
                end
                dawsel_pkg::OP_TAKEN: begin
                    if (in_range) begin
                        logic [31:0] nl;
                        logic [31:0] ns;
                        nl = (qlen_reg[wi] > 32'(item_reg.length)) ?
                             qlen_reg[wi] - 32'(item_reg.length) : '0;
                        ns = sat({1'b0, item_reg.now} + {9'd0, item_reg.length});
                        qlen_reg[wi]  <= nl;
                        start_reg[wi] <= ns;
                        end_reg[wi]   <= sat({1'b0, ns} + {1'b0, nl});
                    end
                end
                dawsel_pkg::OP_SCAN_END: begin
                    // clamp, then end-time minimum; clamped start feeds sum
                    logic [31:0] st;
                    logic [32:0] c1, c2;
                    logic [31:0] en;
                    logic        take;
                    st = (start_reg[ix] < item_reg.now) ? item_reg.now : start_reg[ix];
                    start_reg[ix] <= st;
                    if (end_reg[ix] < item_reg.now) end_reg[ix] <= item_reg.now;
                    c1 = {1'b0, st} + {1'b0, qlen_reg[ix]};
                    c2 = {1'b0, sat(c1)} + {9'd0, elen_reg[ix]};
                    en = sat(c2);
                    take = !forced_reg && eelig_reg[ix] && eknown_reg[ix];
                    ends_reg[ix] <= take ? en : '0;
                    if (!forced_reg && eelig_reg[ix]) begin
                        if (!eknown_reg[ix]) begin
                            forced_reg <= 1'b1;
                            best_reg   <= ix;
                        end else begin
                            if (!have_end_reg || en < best_end_reg) begin
                                best_end_reg <= en;
                                have_end_reg <= 1'b1;
                            end
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                dawsel_pkg::OP_FIT_MUL: begin
                    prod_a_reg <= 48'(alpha_gain) * 48'(diff);
                    prod_b_reg <= 40'(beta_gain) * 40'(epen_reg[ix]);
                end
                dawsel_pkg::OP_SCAN_FIT: begin
                    if (eelig_reg[ix] && (!have_best_reg || fit < best_fit_reg)) begin
                        best_fit_reg  <= fit;
                        best_reg      <= ix;
                        have_best_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                dawsel_pkg::OP_CHARGE: begin
                    result.was_forced    <= forced_reg;
                    result.none_eligible <= !forced_reg && !have_best_reg;
                    if (forced_reg || have_best_reg) begin
                        result.chosen_worker <= 3'(best_reg);
                        result.to_front      <= item_reg.priority_req;
                    end else begin
                        result.chosen_worker <= '0;
                        result.to_front      <= 1'b0;
                    end
                    if (forced_reg || !have_best_reg) begin
                        result.charged_length  <= '0;
                        result.charged_penalty <= '0;
                    end else begin
                        result.charged_length  <= elen_reg[best_reg];
                        result.charged_penalty <= epen_reg[best_reg];
                        end_reg[best_reg]  <= sat({1'b0, end_reg[best_reg]} +
                                                  {9'd0, elen_reg[best_reg]});
                        qlen_reg[best_reg] <= sat({1'b0, qlen_reg[best_reg]} +
                                                  {9'd0, elen_reg[best_reg]});
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == dawsel_pkg::OP_SCAN_END |-> idx_reg < n_reg)
        else $error("end scan past active workers");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == dawsel_pkg::OP_SCAN_FIT |-> !forced_reg)
        else $error("fitness scan on forced task");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == dawsel_pkg::OP_SCAN_FIT |-> $past(cmd.op) == dawsel_pkg::OP_FIT_MUL)
        else $error("fitness compare without product");
endmodule

### rtl/core/dawsel_ctrl.sv
// Controller of the worker selector: sequences load, scans and charge and
// runs the input and result handshakes. Depends on dawsel_pkg.
module dawsel_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  dawsel_pkg::dp_status_t status,
    output dawsel_pkg::dp_cmd_t    cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_DISPATCH, ST_END, ST_MUL, ST_FIT, ST_CHARGE, ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    assign s_ready = state_reg == ST_IDLE && !m_valid_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd = '{op: dawsel_pkg::OP_NONE, clear_idx: 1'b0};
        case (state_reg)
            ST_IDLE:     if (s_valid && s_ready) cmd.op = dawsel_pkg::OP_LOAD;
            ST_DISPATCH: if (status.is_taken) cmd.op = dawsel_pkg::OP_TAKEN;
            ST_END: begin
                if (!status.idx_done) cmd.op = dawsel_pkg::OP_SCAN_END;
                else cmd.clear_idx = 1'b1;
            end
            ST_MUL:      cmd.op = dawsel_pkg::OP_FIT_MUL;
            ST_FIT:      cmd.op = dawsel_pkg::OP_SCAN_FIT;
            ST_CHARGE:   cmd.op = dawsel_pkg::OP_CHARGE;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_valid && s_ready) state_reg <= ST_DISPATCH;
                ST_DISPATCH: begin
                    if (status.is_taken || !status.is_last) state_reg <= ST_IDLE;
                    else state_reg <= ST_END;
                end
                ST_END: begin
                    if (status.idx_done) begin
                        if (status.forced) state_reg <= ST_CHARGE;
                        else state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (status.idx_done) state_reg <= ST_CHARGE;
                    else state_reg <= ST_FIT;
                end
                ST_FIT:    state_reg <= ST_MUL;
                ST_CHARGE: state_reg <= ST_OUT;
                ST_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before taken");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("new item accepted while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |=> m_valid)
        else $error("result not raised after charge");
endmodule

### tb/tb_data_aware_worker_selector.sv
// Testbench for the data-aware worker selector: drives register writes, estimate and
// job-taken items, predicts each decision in a scoreboard class, checks every result.
// Depends on dawsel_pkg and data_aware_worker_selector.
`timescale 1ns / 100ps

module tb_data_aware_worker_selector;

    class selector_scoreboard;
        logic [15:0] alpha;
        logic [15:0] beta;
        logic [3:0]  active;
        logic [31:0] q_start [8];
        logic [31:0] q_len [8];
        logic [31:0] q_end [8];
        logic [23:0] e_len [8];
        logic [23:0] e_pen [8];
        logic        e_elig [8];
        logic        e_known [8];
        dawsel_pkg::out_item_t pending_choices [$];
        int          errors;

        function new();
            alpha = 16'd256;
            beta = 16'd256;
            active = 4'd8;
            errors = 0;
            for (int i = 0; i < 8; i++) begin
                q_start[i] = 0;
                q_len[i] = 0;
                q_end[i] = 0;
                e_len[i] = 0;
                e_pen[i] = 0;
                e_elig[i] = 0;
                e_known[i] = 0;
            end
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? dawsel_pkg::TMAX : s[31:0];
        endfunction

        function void note_item(dawsel_pkg::in_item_t it);
            int          n;
            int          best;
            logic [31:0] ends [8];
            logic [31:0] best_end;
            logic [63:0] fit;
            logic [63:0] best_fit;
            bit          have_end;
            bit          have_best;
            bit          forced;
            dawsel_pkg::out_item_t r;
            int          w;
            w = it.worker;
            if (it.command == dawsel_pkg::CMD_TAKEN) begin
                q_len[w] = (q_len[w] > it.length) ? q_len[w] - it.length : 0;
                q_start[w] = sat_add(it.now, it.length);
                q_end[w] = sat_add(q_start[w], q_len[w]);
                return;
            end
            e_len[w] = it.length;
            e_pen[w] = it.penalty;
            e_elig[w] = it.eligible;
            e_known[w] = it.known;
            if (!it.last) return;
            n = (active > 8) ? 8 : active;
            best_end = dawsel_pkg::TMAX;
            have_end = 0;
            have_best = 0;
            forced = 0;
            best = 0;
            best_fit = 0;
            for (int i = 0; i < n; i++) begin
                if (q_start[i] < it.now) q_start[i] = it.now;
                if (q_end[i] < it.now) q_end[i] = it.now;
                ends[i] = 0;
            end
            for (int i = 0; i < n; i++) begin
                if (!e_elig[i]) continue;
                if (!e_known[i]) begin
                    forced = 1;
                    best = i;
                    break;
                end
                ends[i] = sat_add(sat_add(q_start[i], q_len[i]), e_len[i]);
                if (!have_end || ends[i] < best_end) begin
                    best_end = ends[i];
                    have_end = 1;
                end
            end
            if (!forced) begin
                for (int i = 0; i < n; i++) begin
                    if (!e_elig[i]) continue;
                    fit = 64'(alpha) * 64'(ends[i] - best_end) + 64'(beta) * 64'(e_pen[i]);
                    if (!have_best || fit < best_fit) begin
                        best_fit = fit;
                        best = i;
                        have_best = 1;
                    end
                end
            end
            r = '0;
            if (!forced && !have_best) begin
                r.none_eligible = 1;
            end else begin
                if (!forced) begin
                    q_end[best] = sat_add(q_end[best], e_len[best]);
                    q_len[best] = sat_add(q_len[best], e_len[best]);
                    r.charged_length = e_len[best];
                    r.charged_penalty = e_pen[best];
                end
                r.chosen_worker = best[2:0];
                r.to_front = it.priority_req;
                r.was_forced = forced;
            end
            pending_choices.push_back(r);
        endfunction

        function void check_result(dawsel_pkg::out_item_t got);
            dawsel_pkg::out_item_t exp_r;
            if (pending_choices.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending_choices.pop_front();
            if (got.chosen_worker !== exp_r.chosen_worker)
                $display("%0t: chosen_worker exp %0d got %0d", $time,
                         exp_r.chosen_worker, got.chosen_worker);
            if (got.charged_length !== exp_r.charged_length)
                $display("%0t: charged_length exp %h got %h", $time,
                         exp_r.charged_length, got.charged_length);
            if (got.charged_penalty !== exp_r.charged_penalty)
                $display("%0t: charged_penalty exp %h got %h", $time,
                         exp_r.charged_penalty, got.charged_penalty);
            if (got.to_front !== exp_r.to_front)
                $display("%0t: to_front exp %b got %b", $time, exp_r.to_front, got.to_front);
            if (got.was_forced !== exp_r.was_forced)
                $display("%0t: was_forced exp %b got %b", $time,
                         exp_r.was_forced, got.was_forced);
            if (got.none_eligible !== exp_r.none_eligible)
                $display("%0t: none_eligible exp %b got %b", $time,
                         exp_r.none_eligible, got.none_eligible);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    dawsel_pkg::in_item_t  s_item;
    logic        m_valid;
    logic        m_ready;
    dawsel_pkg::out_item_t m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    selector_scoreboard sb;
    logic [31:0] tick;
    bit          hold_off;
    int          idle_count;
    int          sent;
    bit          written [8];

    data_aware_worker_selector dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
        if (aresetn && s_valid && s_ready) sb.note_item(s_item);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel || !aresetn)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int d;
        m_ready = 1'b0;
        @(posedge aclk);
        while (1) begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_off = 0;
            end
            d = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            if (d > 0) begin
                m_ready <= 1'b0;
                repeat (d) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        case (idx)
            dawsel_pkg::REG_ALPHA: sb.alpha = val[15:0];
            dawsel_pkg::REG_BETA: sb.beta = val[15:0];
            default: sb.active = val[3:0];
        endcase
    endtask

    task automatic send_item(dawsel_pkg::in_item_t it, bit no_gap);
        int d;
        d = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (d > 0) begin
            s_valid <= 1'b0;
            repeat (d) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tick = it.now;
        sent++;
        if (it.command == dawsel_pkg::CMD_ESTIMATE) written[it.worker] = 1;
    endtask

    function automatic logic [23:0] rnd24();
        case ($urandom_range(0, 4))
            0: return 24'h0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(0, 1000));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] next_now();
        case ($urandom_range(0, 19))
            0: return 32'hFFFFFFFF;
            1: return tick;
            2: return 32'($urandom);
            default: return tick + $urandom_range(0, 5000);
        endcase
    endfunction

    function automatic dawsel_pkg::in_item_t make_est(int w, bit lst);
        dawsel_pkg::in_item_t it;
        it = '0;
        it.command = dawsel_pkg::CMD_ESTIMATE;
        it.worker = w[2:0];
        it.eligible = $urandom_range(0, 3) != 0;
        it.known = $urandom_range(0, 9) != 0;
        it.length = rnd24();
        it.penalty = rnd24();
        it.priority_req = 1'($urandom_range(0, 1));
        it.last = lst;
        it.now = next_now();
        return it;
    endfunction

    function automatic dawsel_pkg::in_item_t make_taken();
        dawsel_pkg::in_item_t it;
        it = make_est($urandom_range(0, 7), 0);
        it.command = dawsel_pkg::CMD_TAKEN;
        it.eligible = 1'($urandom_range(0, 1));
        it.known = 1'($urandom_range(0, 1));
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_task(int n, bit no_gap);
        dawsel_pkg::in_item_t it;
        for (int w = 0; w < 8; w++) begin
            if (w < n || !written[w] || $urandom_range(0, 3) == 0) begin
                it = make_est(w, 0);
                if (w == 7) it.last = 1;
                send_item(it, no_gap);
            end
        end
        if (!s_item.last) begin
            it = make_est($urandom_range(0, 7), 1);
            send_item(it, no_gap);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_choices.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        dawsel_pkg::in_item_t it;
        int       n;
        bit       pressed;
        sb = new();
        tick = 0;
        hold_off = 0;
        idle_count = 0;
        sent = 0;
        pressed = 0;
        for (int i = 0; i < 8; i++) written[i] = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int w = 0; w < 8; w++) begin
            it = '0;
            it.worker = w[2:0];
            it.eligible = 1;
            it.known = 1;
            it.length = (w == 0) ? 24'hFFFFFF : 24'(w * 10);
            it.penalty = (w == 1) ? 24'hFFFFFF : 24'd5;
            it.last = (w == 7);
            it.now = 32'd100;
            send_item(it, 0);
        end
        for (int w = 0; w < 8; w++) begin
            it = '0;
            it.worker = w[2:0];
            it.eligible = (w != 2);
            it.known = (w != 5);
            it.length = 24'd7;
            it.priority_req = 1;
            it.last = (w == 7);
            it.now = 32'hFFFFFFFF;
            send_item(it, 0);
        end
        it = '0;
        it.command = dawsel_pkg::CMD_TAKEN;
        it.worker = 3;
        it.length = 24'hFFFFFF;
        it.now = 32'hFFFFFF00;
        send_item(it, 0);
        for (int w = 0; w < 8; w++) begin
            it = '0;
            it.worker = w[2:0];
            it.last = (w == 7);
            it.now = 32'd5;
            send_item(it, 0);
        end
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: reg_write(dawsel_pkg::REG_ACTIVE, 32'd0);
                1: begin
                    reg_write(dawsel_pkg::REG_ALPHA, 32'd0);
                    reg_write(dawsel_pkg::REG_ACTIVE, 32'd1);
                end
                2: begin
                    reg_write(dawsel_pkg::REG_ALPHA, 32'hFFFF);
                    reg_write(dawsel_pkg::REG_BETA, 32'd0);
                    reg_write(dawsel_pkg::REG_ACTIVE, 32'd15);
                end
                3: begin
                    reg_write(dawsel_pkg::REG_BETA, 32'hFFFF);
                    reg_write(dawsel_pkg::REG_ACTIVE, 32'd8);
                end
                default: begin
                    reg_write(dawsel_pkg::REG_ALPHA, $urandom_range(0, 65535));
                    reg_write(dawsel_pkg::REG_BETA, $urandom_range(0, 65535));
                    reg_write(dawsel_pkg::REG_ACTIVE, $urandom_range(1, 8));
                end
            endcase
            while (sent < (ph + 1) * 160) begin
                n = $urandom_range(0, 8);
                if ($urandom_range(0, 5) == 0) begin
                    send_item(make_taken(), 0);
                end else if ($urandom_range(0, 9) == 0) begin
                    send_item(make_est($urandom_range(0, 7), 1'($urandom_range(0, 1))), 0);
                end else begin
                    if (ph == 5 && !pressed && sent >= 5 * 160 + 20) begin
                        hold_off = 1;
                        pressed = 1;
                    end
                    send_task(n, ph == 5);
                end
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
